// ===== design/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// mft_pkg - shared definitions for the Manchester frame transmitter
// Request codes, status codes, frame constants, the nibble-to-symbol
// encoder, the CRC-16-CCITT byte update and the symbol information record.
// ----------------------------------------------------------------------------
package mft_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_COMMIT = 2'd1,
      OP_TICK   = 2'd2
   } opcode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [7:0]  PREAMBLE_0 = 8'h7f;
   localparam logic [7:0]  PREAMBLE_1 = 8'h55;
   localparam logic [7:0]  PREAMBLE_2 = 8'h57;
   localparam logic [15:0] CRC_INIT   = 16'hffff;
   localparam logic [15:0] CRC_POLY   = 16'h8408;

   // Symbol for the current position and what the CRC needs from it.
   typedef struct packed {
      logic [7:0] symbol;
      logic [7:0] msg_byte;
      logic       crc_take;
   } sym_info_type;

   // Each data bit becomes two line bits: a one as 10, a zero as 01.
   function automatic logic [7:0] mpe_symbol(input logic [3:0] nib);
      logic [7:0] sym;
      sym = '0;
      for (int i = 0; i < 4; i++) begin
         sym[2*i +: 2] = nib[i] ? 2'b10 : 2'b01;
      end
      return sym;
   endfunction

   // Reflected CRC-16-CCITT, one byte.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

endpackage

// ===== design/mft_ram.sv =====
// ----------------------------------------------------------------------------
// mft_ram - generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mft_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mft_sym_sel.sv =====
// ----------------------------------------------------------------------------
// mft_sym_sel - symbol selection
// Works out the line symbol for the current symbol position: preamble,
// Manchester-coded count and payload nibbles, or the complemented CRC.
// ----------------------------------------------------------------------------
module mft_sym_sel #(
   parameter int unsigned MAX_PAYLOAD = mft_pkg::MAX_PAYLOAD_DEF,
   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1),
   localparam int unsigned SW = $clog2(2 * MAX_PAYLOAD + 10)
) (
   input  logic [SW-1:0]         sym_pos,
   input  logic [CW-1:0]         count,
   input  logic [7:0]            rd_data,
   input  logic [15:0]           crc,
   output mft_pkg::sym_info_type info
);

   import mft_pkg::*;

   logic [SW-1:0] msg_syms;
   logic [SW-1:0] t;
   logic [SW-1:0] j;
   logic [SW-1:0] k;
   logic [7:0]    count_byte;
   logic [7:0]    b;
   logic [3:0]    nib;
   logic [15:0]   crc_c;

   always_comb begin
      msg_syms   = SW'({count, 1'b0}) + SW'(2);
      count_byte = 8'(32'(count) + 32'd3);
      t          = sym_pos - SW'(3);
      j          = t - msg_syms;
      k          = t >> 1;
      b          = (k == '0) ? count_byte : rd_data;
      nib        = t[0] ? b[3:0] : b[7:4];
      crc_c      = ~crc;

      info.msg_byte = b;
      info.crc_take = 1'b0;
      if (sym_pos < SW'(3)) begin
         case (sym_pos[1:0])
            2'd0:    info.symbol = PREAMBLE_0;
            2'd1:    info.symbol = PREAMBLE_1;
            default: info.symbol = PREAMBLE_2;
         endcase
      end else if (t < msg_syms) begin
         info.symbol   = mpe_symbol(nib);
         info.crc_take = t[0];
      end else begin
         // CRC goes out low byte first, high nibble of each byte first.
         case (j[1:0])
            2'd0:    info.symbol = mpe_symbol(crc_c[7:4]);
            2'd1:    info.symbol = mpe_symbol(crc_c[3:0]);
            2'd2:    info.symbol = mpe_symbol(crc_c[15:12]);
            default: info.symbol = mpe_symbol(crc_c[11:8]);
         endcase
      end
   end

endmodule

// ===== design/manchester_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// manchester_frame_transmitter - Manchester frame encoder with CRC-16-CCITT
// The block takes one request in every clock cycle (busy is always low) and
// gives exactly one result for it, on the rsp_ ports with rsp_strobe high,
// in the cycle after the request. The receiver cannot stall the result and
// needs none: each result lasts one cycle and the next follows at once.
// The rate is set by the state registers and the payload RAM, whose
// registered read port is addressed from the next symbol position, so
// the payload byte is ready when a tick needs it. Appends store payload
// bytes; a commit starts a frame; each tick sends one line bit, most
// significant bit first.
// ----------------------------------------------------------------------------
//
// A frame is three raw preamble bytes (0x7f, 0x55, 0x57) followed by
// Manchester symbols, one per nibble, for the count byte (payload length
// plus three), the payload and the complemented CRC, low byte first. The
// CRC is the reflected CCITT polynomial started at all ones and covers the
// count byte and the payload; it takes in each byte once the last bit of
// that byte's low-nibble symbol has gone out. After the final bit the line
// is low, the payload buffer is emptied and the block is idle again.
//
// Appends while a frame is being sent, or once the buffer is full, are
// rejected with a status code, as is a commit during a frame. A tick while
// idle and the unused request code have no effect.

module manchester_frame_transmitter #(
   parameter int unsigned MAX_PAYLOAD = mft_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_data_byte,

   output logic       rsp_strobe,
   output logic       rsp_line_level,
   output logic       rsp_busy_res,
   output logic       rsp_frame_done,
   output logic [1:0] rsp_status
);

   import mft_pkg::*;

   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned SW = $clog2(2 * MAX_PAYLOAD + 10);
   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Frame state.
   logic          sending_ff, sending_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sym_pos_ff, sym_pos_in;
   logic [2:0]    bit_pos_ff, bit_pos_in;
   logic [15:0]   crc_ff, crc_in;

   // Result registers.
   logic          strobe_ff, strobe_in;
   logic          line_ff, line_in;
   logic          done_ff, done_in;
   logic [1:0]    status_ff, status_in;

   // Payload buffer ports.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   sym_info_type  info;
   logic [SW-1:0] sym_next;
   logic [SW-1:0] total;

   // Every request is taken in the cycle it is offered.
   assign busy = 1'b0;

   mft_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mft_sym_sel #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_sym_sel (
      .sym_pos (sym_pos_ff),
      .count   (count_ff),
      .rd_data (rd_data),
      .crc     (crc_ff),
      .info    (info)
   );

   always_comb begin
      sending_in = sending_ff;
      count_in   = count_ff;
      sym_pos_in = sym_pos_ff;
      bit_pos_in = bit_pos_ff;
      crc_in     = crc_ff;
      strobe_in  = start;
      line_in    = 1'b0;
      done_in    = 1'b0;
      status_in  = ST_OK;
      wr_en      = 1'b0;
      wr_addr    = AW'(count_ff);
      sym_next   = sym_pos_ff + SW'(1);
      total      = SW'({count_ff, 1'b0}) + SW'(9);

      if (start) begin
         case (req_opcode)
            OP_APPEND: begin
               if (sending_ff) begin
                  status_in = ST_BUSY;
               end else if (count_ff >= CW'(MAX_PAYLOAD)) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_COMMIT: begin
               if (sending_ff) begin
                  status_in = ST_BUSY;
               end else begin
                  sending_in = 1'b1;
                  sym_pos_in = '0;
                  bit_pos_in = 3'd7;
                  crc_in     = CRC_INIT;
               end
            end
            OP_TICK: begin
               if (sending_ff) begin
                  line_in = info.symbol[bit_pos_ff];
                  if (bit_pos_ff != 3'd0) begin
                     bit_pos_in = bit_pos_ff - 3'd1;
                  end else begin
                     bit_pos_in = 3'd7;
                     if (info.crc_take) begin
                        crc_in = crc_byte(crc_ff, info.msg_byte);
                     end
                     sym_pos_in = sym_next;
                     if (sym_next >= total) begin
                        done_in    = 1'b1;
                        sending_in = 1'b0;
                        sym_pos_in = '0;
                        count_in   = '0;
                        crc_in     = CRC_INIT;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Look one symbol ahead: payload byte n sits under symbols 2n+5 and
      // 2n+6, so the read data matches the symbol position next cycle.
      rd_addr = AW'((sym_pos_in - SW'(5)) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         count_ff   <= '0;
         sym_pos_ff <= '0;
         bit_pos_ff <= 3'd7;
         crc_ff     <= CRC_INIT;
         strobe_ff  <= 1'b0;
      end else begin
         sending_ff <= sending_in;
         count_ff   <= count_in;
         sym_pos_ff <= sym_pos_in;
         bit_pos_ff <= bit_pos_in;
         crc_ff     <= crc_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff   <= line_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_line_level = line_ff;
   assign rsp_busy_res   = sending_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_status     = status_ff;

endmodule

// ===== bench/manchester_frame_transmitter_tb.sv =====
// ----------------------------------------------------------------------------
// manchester_frame_transmitter_tb - self-checking bench for the frame encoder
// Drives append, commit and tick requests through the start/busy handshake
// and compares every strobed response, field by field, with its typed value or
// a behavioural model of the line encoder kept inside the bench. A short table
// of directed requests comes first, then three phases of random frames.
// ----------------------------------------------------------------------------
module manchester_frame_transmitter_tb;
   import mft_pkg::*;

   localparam int PAYLOAD_DEPTH = MAX_PAYLOAD_DEF;
   // Request code with no function in the block; it must leave all state alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles with neither a request accepted nor a response seen before the
   // run is declared hung. Sender gaps are random but short, so this is ample.
   localparam int STALL_LIMIT = 2000;
   // The response is registered and comes in the cycle after its request; spare
   // cycles at the end catch any stray strobe.
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic       level;
      logic       active;
      logic       done;
      logic [1:0] status;
   } tx_result_type;

   // The response to a request that, with no frame active, changes nothing, sends no bit and is not rejected.
   localparam tx_result_type QUIET = '{1'b0, 1'b0, 1'b0, ST_OK};

   typedef struct packed {
      logic [1:0]    op;
      logic [7:0]    data;
      int            reps;
      bit            typed;
      tx_result_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_opcode = OP_TICK;
   logic [7:0] req_data_byte = 8'h00;
   logic       busy;
   logic       rsp_strobe;
   logic       rsp_line_level;
   logic       rsp_busy_res;
   logic       rsp_frame_done;
   logic [1:0] rsp_status;

   manchester_frame_transmitter #(
      .MAX_PAYLOAD (PAYLOAD_DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Line encoder model. It mirrors the block's state: the payload buffer, the
   // byte count, the symbol being sent and the bit within it (most significant
   // first), the running CRC and whether a frame is on the line.
   // -------------------------------------------------------------------------
   logic [7:0]  model_payload [PAYLOAD_DEPTH];
   int          model_count  = 0;
   int          model_symbol = 0;
   int          model_bit    = 7;
   logic [15:0] model_crc    = CRC_INIT;
   bit          frame_active = 1'b0;

   // Each data bit becomes a pair of line bits: a one as 10, a zero as 01.
   // Starting from all-zero pairs (0x55), a one simply flips its pair.
   function automatic logic [7:0] nibble_symbol(input logic [3:0] nib);
      return 8'h55 ^ {{2{nib[3]}}, {2{nib[2]}}, {2{nib[1]}}, {2{nib[0]}}};
   endfunction

   // Reflected CRC-16-CCITT, fed one byte, least significant bit first.
   function automatic logic [15:0] crc_absorb(input logic [15:0] crc,
                                              input logic [7:0]  b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 16'h0000);
      return acc;
   endfunction

   // Byte k of the protected message: the count byte first, then the payload.
   function automatic logic [7:0] message_byte(input int k);
      int count_byte;
      count_byte = model_count + 3;
      if (k == 0) return count_byte[7:0];
      return model_payload[k - 1];
   endfunction

   // The eight line bits currently being sent. The preamble goes out raw; the
   // message and the complemented CRC go out as one symbol per nibble, high
   // nibble first, with the CRC's low byte ahead of its high byte.
   function automatic logic [7:0] symbol_on_air();
      int          s;
      int          msg_syms;
      logic [7:0]  b;
      logic [15:0] c;
      s = model_symbol;
      msg_syms = 2 * (model_count + 1);
      if (s == 0) return PREAMBLE_0;
      if (s == 1) return PREAMBLE_1;
      if (s == 2) return PREAMBLE_2;
      s = s - 3;
      if (s < msg_syms) begin
         b = message_byte(s >> 1);
         return nibble_symbol(s[0] ? b[3:0] : b[7:4]);
      end
      c = ~model_crc;
      case (s - msg_syms)
         0:       return nibble_symbol(c[7:4]);
         1:       return nibble_symbol(c[3:0]);
         2:       return nibble_symbol(c[15:12]);
         default: return nibble_symbol(c[11:8]);
      endcase
   endfunction

   // Advances the model by one request and gives the response it calls for.
   function automatic tx_result_type transmit_step(input logic [1:0] op,
                                                   input logic [7:0] data);
      tx_result_type r;
      logic [7:0]    sym;
      int            s;
      r = QUIET;
      case (op)
         OP_APPEND: begin
            if (frame_active) begin
               r.status = ST_BUSY;
            end else if (model_count >= PAYLOAD_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_payload[model_count] = data;
               model_count++;
            end
         end
         OP_COMMIT: begin
            if (frame_active) begin
               r.status = ST_BUSY;
            end else begin
               frame_active = 1'b1;
               model_symbol = 0;
               model_bit = 7;
               model_crc = CRC_INIT;
            end
         end
         OP_TICK: begin
            if (frame_active) begin
               sym = symbol_on_air();
               r.level = sym[model_bit];
               if (model_bit != 0) begin
                  model_bit--;
               end else begin
                  // A message byte enters the CRC once its low-nibble symbol,
                  // which is the odd one of the pair, has fully gone out.
                  model_bit = 7;
                  s = model_symbol - 3;
                  if (s >= 0 && s < 2 * (model_count + 1) && s[0])
                     model_crc = crc_absorb(model_crc, message_byte(s >> 1));
                  model_symbol++;
                  if (model_symbol >= 2 * (model_count + 1) + 7) begin
                     r.done = 1'b1;
                     frame_active = 1'b0;
                     model_symbol = 0;
                     model_count = 0;
                     model_crc = CRC_INIT;
                  end
               end
            end
         end
         default: ;
      endcase
      r.active = frame_active;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. Responses due are queued in request order; the checker
   // below retires them one per strobe.
   // -------------------------------------------------------------------------
   tx_result_type line_results_due [$];
   int            sender_idle_pct   = 0;
   int            requests_counted  = 0;
   int            mismatches        = 0;
   int            responses_seen    = 0;
   int            quiet_cycles      = 0;

   // Presents one request, optionally after a random gap, and holds it until
   // the block takes it. A typed row supplies its own expected response; the
   // model still runs so that its state keeps pace with the block.
   task automatic send_request(input logic [1:0] op, input logic [7:0] data,
                               input bit typed, input tx_result_type typed_want);
      tx_result_type predicted;
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // Idle ticks and the unused code do nothing, so they are not counted
      // towards the size of a phase.
      if (!(op == OP_UNUSED || (op == OP_TICK && !frame_active)))
         requests_counted++;
      predicted = transmit_step(op, data);
      line_results_due.push_back(typed ? typed_want : predicted);
   endtask

   // Random frames: appends, a commit and then ticks until the frame is out.
   // Most payloads are short so that many frames fit in a phase; now and then
   // the buffer is overfilled to reach the full case. A few stray requests
   // are sprinkled in, and occasionally the commit is left out so that the
   // bytes carry over into the next frame.
   task automatic run_phase(input int idle_pct, input int quota);
      int         first;
      int         n;
      int         pick;
      logic [1:0] stray_op;
      sender_idle_pct = idle_pct;
      first = requests_counted;
      while (requests_counted - first < quota) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) n = PAYLOAD_DEPTH + 1;
         else if (pick < 30) n = $urandom_range(12, 4);
         else n = $urandom_range(3, 0);
         repeat (n) send_request(OP_APPEND, 8'($urandom_range(255, 0)), 1'b0, QUIET);
         if ($urandom_range(9, 0) == 0) begin
            repeat ($urandom_range(3, 1)) begin
               stray_op = 2'($urandom_range(3, 0));
               send_request(stray_op, 8'($urandom_range(255, 0)), 1'b0, QUIET);
            end
         end
         if ($urandom_range(19, 0) != 0)
            send_request(OP_COMMIT, 8'($urandom_range(255, 0)), 1'b0, QUIET);
         while (frame_active) begin
            if ($urandom_range(99, 0) < 4) begin
               stray_op = 2'($urandom_range(3, 0));
               send_request(stray_op, 8'($urandom_range(255, 0)), 1'b0, QUIET);
            end else begin
               send_request(OP_TICK, 8'($urandom_range(255, 0)), 1'b0, QUIET);
            end
         end
      end
   endtask

   // Directed requests. Rows with a typed response cover the idle cases, the
   // rejections and the first preamble bits; the long runs of ticks and
   // appends are left to the model. An empty frame is 72 ticks long and a
   // full one (32 bytes) 584.
   stim_row_type directed_rows [18] = '{
      '{OP_TICK,   8'h00,   1, 1'b1, QUIET},                            // tick while idle
      '{OP_UNUSED, 8'hff,   1, 1'b1, QUIET},                            // unused code
      '{OP_COMMIT, 8'h00,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_OK}},       // empty frame
      '{OP_COMMIT, 8'h00,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_BUSY}},     // commit in frame
      '{OP_APPEND, 8'ha5,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_BUSY}},     // append in frame
      '{OP_TICK,   8'h00,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_OK}},       // 0x7f, bit 7
      '{OP_TICK,   8'hff,   1, 1'b1, '{1'b1, 1'b1, 1'b0, ST_OK}},       // 0x7f, bit 6
      '{OP_TICK,   8'h00,  70, 1'b0, QUIET},
      '{OP_TICK,   8'h00,   1, 1'b1, QUIET},
      '{OP_APPEND, 8'h00,   1, 1'b1, QUIET},
      '{OP_APPEND, 8'hff,   1, 1'b1, QUIET},
      '{OP_APPEND, 8'h3c,  30, 1'b0, QUIET},
      '{OP_APPEND, 8'h81,   1, 1'b1, '{1'b0, 1'b0, 1'b0, ST_FULL}},     // buffer full
      '{OP_UNUSED, 8'h00,   1, 1'b1, QUIET},
      '{OP_COMMIT, 8'hff,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_OK}},
      '{OP_APPEND, 8'h00,   1, 1'b1, '{1'b0, 1'b1, 1'b0, ST_BUSY}},
      '{OP_TICK,   8'h00, 584, 1'b0, QUIET},
      '{OP_TICK,   8'h00,   1, 1'b1, QUIET}
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps)
            send_request(directed_rows[i].op, directed_rows[i].data,
                         directed_rows[i].typed, directed_rows[i].want);
      end
      // The sender first idles now and then, then often, then never.
      run_phase(16, 300);
      run_phase(47, 300);
      run_phase(0, 300);
      start <= 1'b0;
      while (line_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response checker. The receiver cannot stall the block, so every strobe
   // is a response taken at that edge and must match the oldest one due.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      $display("mismatch on response %0d: %s is %0h, expected %0h",
               responses_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      tx_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         responses_seen++;
         if (line_results_due.size() == 0) begin
            report_mismatch("response with no request due", 8'h01, 8'h00);
         end else begin
            want = line_results_due.pop_front();
            if (rsp_line_level !== want.level)
               report_mismatch("line level", 8'(rsp_line_level), 8'(want.level));
            if (rsp_busy_res !== want.active)
               report_mismatch("busy", 8'(rsp_busy_res), 8'(want.active));
            if (rsp_frame_done !== want.done)
               report_mismatch("frame done", 8'(rsp_frame_done), 8'(want.done));
            if (rsp_status !== want.status)
               report_mismatch("status", 8'(rsp_status), 8'(want.status));
         end
      end
   end

   // Watchdog: a hung handshake or a response that never comes stops the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
design/mft_pkg.sv
design/mft_ram.sv
design/mft_sym_sel.sv
design/manchester_frame_transmitter.sv
bench/manchester_frame_transmitter_tb.sv
